// ===== rtl/region_containment_test_defines.svh =====
// assertion macros for the region containment test
// used by rct_ctrl, the rtl file that carries concurrent checks; needs clk and arst_n in scope
`ifndef REGION_CONTAINMENT_TEST_DEFINES_SVH
`define REGION_CONTAINMENT_TEST_DEFINES_SVH

`ifndef ASSERT_OFF
// property holds at every clock edge outside reset
`define RCT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// condition never holds outside reset
`define RCT_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define RCT_ASSERT(lbl, prop, msg)
`define RCT_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/rct_pkg.sv =====
// shared types and constants for the region containment test
// no dependencies
package rct_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CYL_D,
		ST_CYL_R,
		ST_POLY,
		ST_CLOSE,
		ST_DRAIN,
		ST_DONE
	} ctl_state_t;

	// kind of work carried by a pipeline token
	typedef enum logic [2:0] {
		TK_FIRST,
		TK_MID,
		TK_CLOSE,
		TK_CYL_D,
		TK_CYL_R
	} tok_kind_t;

	localparam int MODE_WIDTH    = 2;
	localparam int REG_IDX_WIDTH = 3;
	localparam int VIDX_WIDTH    = 5;
	localparam int VCNT_WIDTH    = 6;
	localparam int MIN_VERTICES  = 3;

	localparam logic [MODE_WIDTH-1:0] MODE_CYL  = 2'd0;
	localparam logic [MODE_WIDTH-1:0] MODE_BOX  = 2'd1;
	localparam logic [MODE_WIDTH-1:0] MODE_POLY = 2'd2;

	localparam logic [REG_IDX_WIDTH-1:0] REG_SHAPE_MODE   = 3'd0;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CORNER_A_X   = 3'd1;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CORNER_A_Y   = 3'd2;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CORNER_A_Z   = 3'd3;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CORNER_B_X   = 3'd4;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CORNER_B_Y   = 3'd5;
	localparam logic [REG_IDX_WIDTH-1:0] REG_CORNER_B_Z   = 3'd6;
	localparam logic [REG_IDX_WIDTH-1:0] REG_VERTEX_COUNT = 3'd7;

	// controller to datapath
	typedef struct packed {
		logic      start;
		logic      vwrite;
		logic      issue;
		tok_kind_t kind;
		logic      load_out;
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic busy;
		logic out_free;
	} dp_status_t;

endpackage

// ===== rtl/rct_cfg.sv =====
// configuration registers of the region containment test
// depends on rct_pkg
module rct_cfg #(
	parameter int COORD_WIDTH  = 24,
	parameter int MAX_VERTICES = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [rct_pkg::REG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [COORD_WIDTH-1:0]                cfg_data,
	output logic [rct_pkg::MODE_WIDTH-1:0]        shape_mode,
	output logic signed [COORD_WIDTH-1:0]         ca_x,
	output logic signed [COORD_WIDTH-1:0]         ca_y,
	output logic signed [COORD_WIDTH-1:0]         ca_z,
	output logic signed [COORD_WIDTH-1:0]         cb_x,
	output logic signed [COORD_WIDTH-1:0]         cb_y,
	output logic signed [COORD_WIDTH-1:0]         cb_z,
	output logic [$clog2(MAX_VERTICES+1)-1:0]     vcount
);
	import rct_pkg::*;

	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [VCNT_WIDTH-1:0] vertex_count_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_mode     <= '0;
			ca_x           <= '0;
			ca_y           <= '0;
			ca_z           <= '0;
			cb_x           <= '0;
			cb_y           <= '0;
			cb_z           <= '0;
			vertex_count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHAPE_MODE:   shape_mode     <= cfg_data[MODE_WIDTH-1:0];
				REG_CORNER_A_X:   ca_x           <= cfg_data;
				REG_CORNER_A_Y:   ca_y           <= cfg_data;
				REG_CORNER_A_Z:   ca_z           <= cfg_data;
				REG_CORNER_B_X:   cb_x           <= cfg_data;
				REG_CORNER_B_Y:   cb_y           <= cfg_data;
				REG_CORNER_B_Z:   cb_z           <= cfg_data;
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data[VCNT_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// count saturates at the table depth
	assign vcount = (int'(vertex_count_q) > MAX_VERTICES) ? NW'(MAX_VERTICES)
	                                                      : NW'(vertex_count_q);

endmodule

// ===== rtl/rct_datapath.sv =====
// datapath: vertex table, edge pipeline with shared multipliers, result register
// depends on rct_pkg
module rct_datapath #(
	parameter int COORD_WIDTH   = 24,
	parameter int MAX_VERTICES  = 32,
	parameter int CROSS_EPSILON = 7
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  rct_pkg::ctl_cmd_t                      cmd,
	input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
	output rct_pkg::dp_status_t                    st,
	input  logic signed [COORD_WIDTH-1:0]          point_x,
	input  logic signed [COORD_WIDTH-1:0]          point_y,
	input  logic signed [COORD_WIDTH-1:0]          point_z,
	input  logic [rct_pkg::VIDX_WIDTH-1:0]         vertex_index,
	input  logic signed [COORD_WIDTH-1:0]          vertex_x,
	input  logic signed [COORD_WIDTH-1:0]          vertex_z,
	input  logic [rct_pkg::MODE_WIDTH-1:0]         shape_mode,
	input  logic signed [COORD_WIDTH-1:0]          ca_x,
	input  logic signed [COORD_WIDTH-1:0]          ca_y,
	input  logic signed [COORD_WIDTH-1:0]          ca_z,
	input  logic signed [COORD_WIDTH-1:0]          cb_x,
	input  logic signed [COORD_WIDTH-1:0]          cb_y,
	input  logic signed [COORD_WIDTH-1:0]          cb_z,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]      vcount,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   inside_res,
	output logic                                   too_few_vertices
);
	import rct_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int AW = $clog2(MAX_VERTICES);
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int XW = PW + 1;
	localparam logic signed [XW-1:0] EPS_POS = XW'(CROSS_EPSILON);
	localparam logic signed [XW-1:0] EPS_NEG = -XW'(CROSS_EPSILON);

	logic [2*CW-1:0] vtab [MAX_VERTICES];
	logic [2*CW-1:0] rd_data_q;
	logic            wr_en;

	logic signed [CW-1:0] px_q, py_q, pz_q;
	logic signed [CW-1:0] first_x_q, first_z_q, prev_x_q, prev_z_q;
	logic signed [CW-1:0] rd_x, rd_z, b_x, b_z;

	logic      tok_v_s1, tok_v_s2, tok_v_s3;
	tok_kind_t tok_k_s1, tok_k_s2, tok_k_s3;

	logic signed [DW-1:0] d1, d2, d3, d4;
	logic signed [DW-1:0] d1_s2, d2_s2, d3_s2, d4_s2;
	logic signed [PW-1:0] p1_s3, p2_s3;
	logic signed [XW-1:0] cross_c;
	logic signed [XW-1:0] sum_q;
	logic                 pos_q, neg_q, cyl_ok_q;

	logic signed [DW-1:0] dx_c, dz_c, dy_c;
	logic [DW-1:0]        adx_c, adz_c, ady_c;
	logic                 box_in, cyl_in, poly_in, few_c, inside_c;
	logic                 out_valid_q, inside_q, few_q;

	// vertex table write and registered read
	assign wr_en = cmd.vwrite && (int'(vertex_index) < MAX_VERTICES);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			vtab[AW'(vertex_index)] <= {vertex_x, vertex_z};
		end
		rd_data_q <= vtab[rd_addr];
	end

	assign rd_x = rd_data_q[2*CW-1:CW];
	assign rd_z = rd_data_q[CW-1:0];

	// query point capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
		end
	end

	// token valid and kind through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_v_s1 <= 1'b0;
			tok_v_s2 <= 1'b0;
			tok_v_s3 <= 1'b0;
		end else begin
			tok_v_s1 <= cmd.issue;
			tok_v_s2 <= tok_v_s1;
			tok_v_s3 <= tok_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		tok_k_s1 <= cmd.kind;
		tok_k_s2 <= tok_k_s1;
		tok_k_s3 <= tok_k_s2;
	end

	// horizontal and vertical offsets of the point
	always_comb begin
		dx_c  = DW'(px_q) - DW'(ca_x);
		dz_c  = DW'(pz_q) - DW'(ca_z);
		dy_c  = DW'(ca_y) - DW'(py_q);
		adx_c = dx_c[DW-1] ? DW'(-dx_c) : DW'(dx_c);
		adz_c = dz_c[DW-1] ? DW'(-dz_c) : DW'(dz_c);
		ady_c = dy_c[DW-1] ? DW'(-dy_c) : DW'(dy_c);
	end

	// stage 1: operand differences
	assign b_x = (tok_k_s1 == TK_MID) ? rd_x : first_x_q;
	assign b_z = (tok_k_s1 == TK_MID) ? rd_z : first_z_q;

	always_comb begin
		d1 = '0;
		d2 = '0;
		d3 = '0;
		d4 = '0;
		case (tok_k_s1)
			TK_MID, TK_CLOSE: begin
				d1 = DW'(b_x) - DW'(prev_x_q);
				d2 = DW'(pz_q) - DW'(prev_z_q);
				d3 = DW'(b_z) - DW'(prev_z_q);
				d4 = DW'(px_q) - DW'(prev_x_q);
			end
			TK_CYL_D: begin
				d1 = adx_c;
				d2 = adx_c;
				d3 = adz_c;
				d4 = adz_c;
			end
			TK_CYL_R: begin
				d1 = DW'(cb_x);
				d2 = DW'(cb_x);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		d1_s2 <= d1;
		d2_s2 <= d2;
		d3_s2 <= d3;
		d4_s2 <= d4;
		if (tok_v_s1 && tok_k_s1 == TK_FIRST) begin
			first_x_q <= rd_x;
			first_z_q <= rd_z;
		end
		if (tok_v_s1 && (tok_k_s1 == TK_FIRST || tok_k_s1 == TK_MID)) begin
			prev_x_q <= rd_x;
			prev_z_q <= rd_z;
		end
	end

	// stage 2: the two products
	always_ff @(posedge clk) begin
		p1_s3 <= d1_s2 * d2_s2;
		p2_s3 <= d3_s2 * d4_s2;
	end

	// stage 3: sign class of the cross product, cylinder distance
	assign cross_c = XW'(p1_s3) - XW'(p2_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 1'b0;
			neg_q    <= 1'b0;
			cyl_ok_q <= 1'b0;
		end else if (cmd.start) begin
			pos_q    <= 1'b0;
			neg_q    <= 1'b0;
			cyl_ok_q <= 1'b0;
		end else if (tok_v_s3) begin
			case (tok_k_s3)
				TK_MID, TK_CLOSE: begin
					pos_q <= pos_q | (cross_c > EPS_POS);
					neg_q <= neg_q | (cross_c < EPS_NEG);
				end
				TK_CYL_R: cyl_ok_q <= (sum_q <= XW'(p1_s3));
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tok_v_s3 && tok_k_s3 == TK_CYL_D) begin
			sum_q <= XW'(p1_s3) + XW'(p2_s3);
		end
	end

	// final decision per mode
	always_comb begin
		box_in  = (px_q >= ca_x) && (px_q <= cb_x) &&
		          (py_q >= ca_y) && (py_q <= cb_y) &&
		          (pz_q >= ca_z) && (pz_q <= cb_z);
		cyl_in  = !cb_x[CW-1] && (adx_c <= {1'b0, cb_x}) && (adz_c <= {1'b0, cb_x}) &&
		          !cb_y[CW-1] && (ady_c <= {1'b0, cb_y}) && cyl_ok_q;
		few_c   = int'(vcount) < MIN_VERTICES;
		poly_in = !few_c && !(pos_q && neg_q) && (py_q >= ca_y) && (py_q <= cb_y);
		case (shape_mode)
			MODE_CYL:  inside_c = cyl_in;
			MODE_BOX:  inside_c = box_in;
			MODE_POLY: inside_c = poly_in;
			default:   inside_c = 1'b0;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			inside_q <= inside_c;
			few_q    <= (shape_mode == MODE_POLY) && few_c;
		end
	end

	assign out_valid        = out_valid_q;
	assign inside_res       = inside_q;
	assign too_few_vertices = few_q;
	assign st.busy          = tok_v_s1 | tok_v_s2 | tok_v_s3;
	assign st.out_free      = !out_valid_q || out_ready;

endmodule

// ===== rtl/rct_ctrl.sv =====
// controller: sequences each query through the datapath
// depends on rct_pkg and region_containment_test_defines.svh
`include "region_containment_test_defines.svh"

module rct_ctrl #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                opcode,
	input  logic [rct_pkg::MODE_WIDTH-1:0]      shape_mode,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]   vcount,
	input  rct_pkg::dp_status_t                 st,
	output rct_pkg::ctl_cmd_t                   cmd,
	output logic [$clog2(MAX_VERTICES)-1:0]     rd_addr
);
	import rct_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);

	ctl_state_t    state_q, state_d;
	logic [AW-1:0] k_q;
	logic          last_k, few;

	assign last_k = (int'(k_q) == int'(vcount) - 1);
	assign few    = int'(vcount) < MIN_VERTICES;

	// state and edge counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_POLY) begin
				k_q <= k_q + AW'(1);
			end else begin
				k_q <= '0;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && !opcode) begin
					case (shape_mode)
						MODE_CYL:  state_d = ST_CYL_D;
						MODE_POLY: state_d = few ? ST_DONE : ST_POLY;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_CYL_D: state_d = ST_CYL_R;
			ST_CYL_R: state_d = ST_DRAIN;
			ST_POLY:  state_d = last_k ? ST_CLOSE : ST_POLY;
			ST_CLOSE: state_d = ST_DRAIN;
			ST_DRAIN: state_d = st.busy ? ST_DRAIN : ST_DONE;
			ST_DONE:  state_d = st.out_free ? ST_IDLE : ST_DONE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		in_ready     = (state_q == ST_IDLE);
		cmd.start    = in_ready && in_valid && !opcode;
		cmd.vwrite   = in_ready && in_valid && opcode;
		cmd.issue    = 1'b0;
		cmd.kind     = TK_MID;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_CYL_D: begin
				cmd.issue = 1'b1;
				cmd.kind  = TK_CYL_D;
			end
			ST_CYL_R: begin
				cmd.issue = 1'b1;
				cmd.kind  = TK_CYL_R;
			end
			ST_POLY: begin
				cmd.issue = 1'b1;
				cmd.kind  = (k_q == '0) ? TK_FIRST : TK_MID;
			end
			ST_CLOSE: begin
				cmd.issue = 1'b1;
				cmd.kind  = TK_CLOSE;
			end
			ST_DONE:  cmd.load_out = st.out_free;
			default: ;
		endcase
	end

	assign rd_addr = k_q;

	// checks
	`RCT_ASSERT(a_load_drained, cmd.load_out |-> !st.busy, "result loaded with edges in flight")
	`RCT_ASSERT(a_edge_in_range, (state_q == ST_POLY) |-> (int'(k_q) < int'(vcount)), "edge walk past count")
	`RCT_ASSERT_NEVER(a_idle_issue, (state_q == ST_IDLE) && cmd.issue, "work issued while idle")
	`RCT_ASSERT(a_query_leaves_idle, cmd.start |=> (state_q != ST_IDLE), "query accepted but no work")

endmodule

// ===== rtl/region_containment_test.sv =====
// box, unused-mode and too-few-vertex queries load the result without the pipeline; cylinder
// queries issue two tokens, polygon queries one per vertex and a closing one (one edge per cycle
// through read, difference, multiply and classify); a vertex write gives no word and in_ready stays high
// one item in flight: in_ready stays low from a query's acceptance until its result is loaded,
// which also waits until the previous result word is taken on out_ready
// arst_n clears config registers, controller and output valid; the vertex table is not cleared
module region_containment_test #(
	parameter int MAX_VERTICES  = 32,
	parameter int COORD_WIDTH   = 24,
	parameter int CROSS_EPSILON = 7
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [rct_pkg::REG_IDX_WIDTH-1:0]  cfg_index,
	input  logic [COORD_WIDTH-1:0]             cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic signed [COORD_WIDTH-1:0]      point_x,
	input  logic signed [COORD_WIDTH-1:0]      point_y,
	input  logic signed [COORD_WIDTH-1:0]      point_z,
	input  logic [rct_pkg::VIDX_WIDTH-1:0]     vertex_index,
	input  logic signed [COORD_WIDTH-1:0]      vertex_x,
	input  logic signed [COORD_WIDTH-1:0]      vertex_z,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               inside_res,
	output logic                               too_few_vertices
);
	import rct_pkg::*;

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [MODE_WIDTH-1:0]         shape_mode;
	logic signed [COORD_WIDTH-1:0] ca_x, ca_y, ca_z, cb_x, cb_y, cb_z;
	logic [NW-1:0]                 vcount;
	ctl_cmd_t                      cmd;
	dp_status_t                    st;
	logic [AW-1:0]                 rd_addr;

	// configuration registers
	rct_cfg #(
		.COORD_WIDTH (COORD_WIDTH),
		.MAX_VERTICES(MAX_VERTICES)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.shape_mode(shape_mode),
		.ca_x      (ca_x),
		.ca_y      (ca_y),
		.ca_z      (ca_z),
		.cb_x      (cb_x),
		.cb_y      (cb_y),
		.cb_z      (cb_z),
		.vcount    (vcount)
	);

	// sequencing
	rct_ctrl #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.shape_mode(shape_mode),
		.vcount    (vcount),
		.st        (st),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	// arithmetic and storage
	rct_datapath #(
		.COORD_WIDTH  (COORD_WIDTH),
		.MAX_VERTICES (MAX_VERTICES),
		.CROSS_EPSILON(CROSS_EPSILON)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.rd_addr         (rd_addr),
		.st              (st),
		.point_x         (point_x),
		.point_y         (point_y),
		.point_z         (point_z),
		.vertex_index    (vertex_index),
		.vertex_x        (vertex_x),
		.vertex_z        (vertex_z),
		.shape_mode      (shape_mode),
		.ca_x            (ca_x),
		.ca_y            (ca_y),
		.ca_z            (ca_z),
		.cb_x            (cb_x),
		.cb_y            (cb_y),
		.cb_z            (cb_z),
		.vcount          (vcount),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.inside_res      (inside_res),
		.too_few_vertices(too_few_vertices)
	);

endmodule

// ===== tb/tb_region_containment_test.sv =====
// testbench for region_containment_test: directed and random words in all shape modes
// depends on rct_pkg and the region_containment_test rtl; predicts each query in a scoreboard
`timescale 1ns / 1ps

module tb_region_containment_test;
	import rct_pkg::*;

	localparam int CW = 24;
	localparam int NV = 32;
	localparam longint EPS = 7;
	localparam longint CMAX = 64'sd8388607;
	localparam longint CMIN = -64'sd8388608;
	localparam logic OP_QUERY = 1'b0;
	localparam logic OP_VWRITE = 1'b1;
	localparam logic [MODE_WIDTH-1:0] MODE_UNUSED = 2'd3;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		logic op;
		logic signed [CW-1:0] px, py, pz;
		logic [VIDX_WIDTH-1:0] vi;
		logic signed [CW-1:0] vx, vz;
	} region_word_t;

	typedef struct {
		logic hit;
		logic few;
	} verdict_t;

	// containment predictor and store of pending verdicts
	class containment_board;
		logic [MODE_WIDTH-1:0] mode;
		longint ax, ay, az, bx, by, bz;
		int vcount;
		longint tx[NV], tz[NV];
		verdict_t pending[$];
		int errors;

		function new();
			mode = MODE_CYL;
			ax = 0; ay = 0; az = 0; bx = 0; by = 0; bz = 0;
			vcount = 0;
			errors = 0;
		endfunction

		function void report_mismatch(string msg);
			errors++;
			$display("mismatch at %0t: %s", $realtime, msg);
		endfunction

		function void write_reg(logic [REG_IDX_WIDTH-1:0] idx, logic [CW-1:0] d);
			longint v;
			v = longint'($signed(d));
			case (idx)
				REG_SHAPE_MODE: mode = d[MODE_WIDTH-1:0];
				REG_CORNER_A_X: ax = v;
				REG_CORNER_A_Y: ay = v;
				REG_CORNER_A_Z: az = v;
				REG_CORNER_B_X: bx = v;
				REG_CORNER_B_Y: by = v;
				REG_CORNER_B_Z: bz = v;
				REG_VERTEX_COUNT: vcount = int'(d[VCNT_WIDTH-1:0]);
				default: ;
			endcase
		endfunction

		// sign class of the edge cross product, dead band of EPS
		function int edge_side(int i, int j, longint px, longint pz);
			longint c;
			c = (tx[j] - tx[i]) * (pz - tz[i]) - (tz[j] - tz[i]) * (px - tx[i]);
			if (c > EPS) return 1;
			if (c < -EPS) return -1;
			return 0;
		endfunction

		function void note_input(region_word_t w);
			verdict_t e;
			longint px, py, pz, adx, adz, ady;
			int n;
			bit pos, neg;
			if (w.op == OP_VWRITE) begin
				tx[w.vi] = longint'(w.vx);
				tz[w.vi] = longint'(w.vz);
				return;
			end
			px = longint'(w.px); py = longint'(w.py); pz = longint'(w.pz);
			e.hit = 0;
			e.few = 0;
			case (mode)
				MODE_CYL: begin
					adx = (px > ax) ? px - ax : ax - px;
					adz = (pz > az) ? pz - az : az - pz;
					ady = (ay > py) ? ay - py : py - ay;
					if (bx >= 0 && adx <= bx && adz <= bx)
						e.hit = (adx * adx + adz * adz <= bx * bx) && ady <= by;
				end
				MODE_BOX: begin
					e.hit = px >= ax && px <= bx && py >= ay && py <= by &&
						pz >= az && pz <= bz;
				end
				MODE_POLY: begin
					n = (vcount > NV) ? NV : vcount;
					if (n < MIN_VERTICES) begin
						e.few = 1;
					end else begin
						pos = 0; neg = 0;
						for (int i = 0; i < n; i++) begin
							int s;
							s = edge_side(i, (i + 1 == n) ? 0 : i + 1, px, pz);
							if (s > 0) pos = 1;
							if (s < 0) neg = 1;
						end
						e.hit = !(pos && neg) && py >= ay && py <= by;
					end
				end
				default: ;
			endcase
			pending = {pending, e};
		endfunction

		function void check_result(logic ins, logic few);
			verdict_t e;
			if (pending.size() == 0) begin
				report_mismatch("result word with nothing expected");
				return;
			end
			e = pending.pop_front();
			if (ins !== e.hit)
				report_mismatch($sformatf("inside_res %b, expected %b", ins, e.hit));
			if (few !== e.few)
				report_mismatch($sformatf("too_few_vertices %b, expected %b", few, e.few));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_WIDTH-1:0] cfg_index;
	logic [CW-1:0] cfg_data;
	logic in_valid, in_ready;
	logic opcode;
	logic signed [CW-1:0] point_x, point_y, point_z;
	logic [VIDX_WIDTH-1:0] vertex_index;
	logic signed [CW-1:0] vertex_x, vertex_z;
	logic out_valid, out_ready;
	logic inside_res, too_few_vertices;

	containment_board board;
	bit calm;
	int idle_cycles;

	region_containment_test DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .point_x(point_x), .point_y(point_y), .point_z(point_z),
		.vertex_index(vertex_index), .vertex_x(vertex_x), .vertex_z(vertex_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.inside_res(inside_res), .too_few_vertices(too_few_vertices)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// mostly short gaps, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [CW-1:0] clip(longint v);
		if (v > CMAX) return CMAX[CW-1:0];
		if (v < CMIN) return CMIN[CW-1:0];
		return v[CW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] any_coord();
		return CW'($urandom());
	endfunction

	function automatic longint near(longint c, longint span);
		return c + longint'($urandom_range(0, 2 * span)) - span;
	endfunction

	// result side: sample at rising edge
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			board.check_result(inside_res, too_few_vertices);

	// result side: random back-pressure
	initial begin
		int stall;
		stall = 0;
		out_ready = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				out_ready = 0;
				stall--;
			end else begin
				out_ready = 1;
				stall = pick_gap();
			end
		end
	end

	// watchdog on cycles with no word moving
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("region_containment_test regression: fail");
				$finish;
			end
		end
	end

	// send one word; entered and left at a falling edge
	task automatic send_word(region_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
		opcode = w.op;
		point_x = w.px; point_y = w.py; point_z = w.pz;
		vertex_index = w.vi; vertex_x = w.vx; vertex_z = w.vz;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		board.note_input(w);
		@(negedge clk);
	endtask

	task automatic query(longint x, longint y, longint z);
		region_word_t w;
		w.op = OP_QUERY;
		w.px = clip(x); w.py = clip(y); w.pz = clip(z);
		w.vi = VIDX_WIDTH'($urandom()); w.vx = any_coord(); w.vz = any_coord();
		send_word(w);
	endtask

	task automatic put_vertex(int i, longint x, longint z);
		region_word_t w;
		w.op = OP_VWRITE;
		w.px = any_coord(); w.py = any_coord(); w.pz = any_coord();
		w.vi = i[VIDX_WIDTH-1:0]; w.vx = clip(x); w.vz = clip(z);
		send_word(w);
	endtask

	// drain every pending verdict, then let a vertex write settle
	task automatic wait_idle();
		in_valid = 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (45) @(negedge clk);
	endtask

	task automatic write_reg(logic [REG_IDX_WIDTH-1:0] idx, longint v);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = v[CW-1:0];
		@(negedge clk);
		board.write_reg(idx, v[CW-1:0]);
		cfg_we = 0;
	endtask

	task automatic setup(logic [MODE_WIDTH-1:0] m, longint a_x, longint a_y, longint a_z,
			longint b_x, longint b_y, longint b_z, int cnt);
		wait_idle();
		write_reg(REG_SHAPE_MODE, longint'(m));
		write_reg(REG_CORNER_A_X, a_x);
		write_reg(REG_CORNER_A_Y, a_y);
		write_reg(REG_CORNER_A_Z, a_z);
		write_reg(REG_CORNER_B_X, b_x);
		write_reg(REG_CORNER_B_Y, b_y);
		write_reg(REG_CORNER_B_Z, b_z);
		write_reg(REG_VERTEX_COUNT, longint'(cnt));
	endtask

	// convex octagon outline, scaled and placed per phase
	int ox[8] = '{3, 2, 0, -2, -3, -2, 0, 2};
	int oz[8] = '{0, 2, 3, 2, 0, -2, -3, -2};

	task automatic load_polygon(int n, longint cx, longint cz, longint s);
		for (int i = 0; i < n; i++)
			put_vertex(i, cx + s * ox[i], cz + s * oz[i]);
	endtask

	initial begin
		longint cx, cy, cz, r, h, ex, ey, ez, s;
		int n, kind;
		board = new();
		calm = 0;
		arst_n = 0;
		cfg_we = 0; cfg_index = '0; cfg_data = '0;
		in_valid = 0; opcode = OP_QUERY;
		point_x = '0; point_y = '0; point_z = '0;
		vertex_index = '0; vertex_x = '0; vertex_z = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// every slot gets written before any polygon query
		for (int i = 0; i < NV; i++) put_vertex(i, any_coord(), any_coord());

		// directed: reset registers, a degenerate cylinder at the origin
		query(0, 0, 0);
		query(1, 0, 0);
		query(CMIN, CMAX, CMIN);
		// cylinder at the coordinate extremes, and a negative radius
		setup(MODE_CYL, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, 0);
		query(CMAX, CMIN, CMAX);
		query(CMIN, CMIN, CMIN);
		setup(MODE_CYL, 0, 0, 0, -1, 100, 0, 0);
		query(0, 0, 0);
		// box edges inclusive, and an empty range
		setup(MODE_BOX, -256, -256, -256, 256, 256, 256, 0);
		query(-256, 256, 256);
		query(257, 0, 0);
		setup(MODE_BOX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0);
		query(CMAX, CMIN, CMAX);
		setup(MODE_BOX, 10, 10, 10, 0, 0, 0, 0);
		query(5, 5, 5);
		// too few vertices, then a triangle, then a saturated count
		setup(MODE_POLY, 0, CMIN, 0, 0, CMAX, 0, 2);
		query(0, 0, 0);
		setup(MODE_POLY, 0, -100, 0, 0, 100, 0, 3);
		load_polygon(3, 0, 0, 1000);
		query(0, 0, 0);
		query(0, 101, 0);
		query(100000, 0, 0);
		setup(MODE_POLY, 0, CMIN, 0, 0, CMAX, 0, 63);
		query(0, 0, 0);
		// unused mode
		setup(MODE_UNUSED, 0, 0, 0, 0, 0, 0, 0);
		query(0, 0, 0);

		// random phases
		for (int ph = 0; ph < 16; ph++) begin
			calm = ($urandom_range(0, 3) == 0);
			cx = near(0, 2000000); cy = near(0, 2000000); cz = near(0, 2000000);
			case (ph % 4)
				0: begin
					r = ($urandom_range(0, 9) == 0) ? -longint'($urandom_range(1, 500))
						: longint'($urandom_range(0, 1 << 20));
					h = longint'($urandom_range(0, 1 << 20));
					setup(MODE_CYL, cx, cy, cz, r, h, any_coord(), $urandom_range(0, 63));
					for (int k = 0; k < 55; k++)
						if ($urandom_range(0, 9) == 0)
							query(any_coord(), any_coord(), any_coord());
						else
							query(near(cx, r + r / 4 + 8), near(cy, h + h / 4 + 8),
								near(cz, r + r / 4 + 8));
				end
				1: begin
					ex = longint'($urandom_range(0, 1 << 20));
					ey = longint'($urandom_range(0, 1 << 20));
					ez = longint'($urandom_range(0, 1 << 20));
					setup(MODE_BOX, cx - ex, cy - ey, cz - ez, cx + ex, cy + ey, cz + ez,
						$urandom_range(0, 63));
					for (int k = 0; k < 55; k++)
						if ($urandom_range(0, 9) == 0)
							query(any_coord(), any_coord(), any_coord());
						else
							query(near(cx, ex + ex / 4 + 4), near(cy, ey + ey / 4 + 4),
								near(cz, ez + ez / 4 + 4));
				end
				2: begin
					n = $urandom_range(3, 8);
					s = longint'($urandom_range(1, 1 << 19));
					ey = longint'($urandom_range(0, 1 << 20));
					kind = $urandom_range(0, 4);
					setup(MODE_POLY, any_coord(), cy - ey, any_coord(), any_coord(), cy + ey,
						any_coord(), (kind == 0) ? NV : n);
					load_polygon(n, cx, cz, s);
					for (int k = 0; k < 50; k++) begin
						if ($urandom_range(0, 9) == 0) begin
							// scribble over slots past the loaded outline; with a count of NV these slots are still in use
							put_vertex($urandom_range(n, NV - 1), any_coord(), any_coord());
						end else if ($urandom_range(0, 9) == 0) begin
							query(any_coord(), any_coord(), any_coord());
						end else begin
							query(near(cx, 3 * s + 4), near(cy, ey + ey / 4 + 4),
								near(cz, 3 * s + 4));
						end
					end
				end
				default: begin
					kind = $urandom_range(0, 3);
					setup(kind[MODE_WIDTH-1:0],
						($urandom_range(0, 1)) ? CMIN : CMAX, any_coord(), any_coord(),
						($urandom_range(0, 1)) ? CMIN : CMAX, any_coord(),
						($urandom_range(0, 1)) ? CMIN : CMAX, $urandom_range(0, 63));
					for (int k = 0; k < 45; k++)
						if ($urandom_range(0, 4) == 0)
							put_vertex($urandom(), any_coord(), any_coord());
						else
							query(any_coord(), any_coord(), any_coord());
				end
			endcase
		end

		calm = 0;
		wait_idle();
		repeat (60) @(negedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("region_containment_test regression: pass");
		else
			$display("region_containment_test regression: fail");
		$finish;
	end

endmodule
